@@ design/qmap_hb_pkg.sv @@
// ----------------------------------------------------------------------------
// qmap_hb_pkg
// Types and constants shared by the uplink mux header builder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package qmap_hb_pkg;

    // item actions
    localparam logic ACTION_PACKET = 1'b0;
    localparam logic ACTION_TABLE  = 1'b1;

    // table word selects
    localparam logic [1:0] SEL_IPV4    = 2'd0;
    localparam logic [1:0] SEL_IPV6_HI = 2'd1;
    localparam logic [1:0] SEL_IPV6_LO = 2'd2;
    localparam logic [1:0] SEL_MUX_ID  = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_IPV4     = 2'd0;
    localparam logic [1:0] STATUS_IPV6     = 2'd1;
    localparam logic [1:0] STATUS_NOT_IP   = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    localparam logic [3:0] VERSION_IPV4 = 4'h4;
    localparam logic [3:0] VERSION_IPV6 = 4'h6;

    localparam int COUNT_W = 17;
    localparam int LEN_W   = COUNT_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [COUNT_W-1:0] V4_SRC_FIRST = 17'd12;
    localparam logic [COUNT_W-1:0] V4_SRC_LAST  = 17'd15;
    localparam logic [COUNT_W-1:0] V6_HI_FIRST  = 17'd8;
    localparam logic [COUNT_W-1:0] V6_HI_LAST   = 17'd15;
    localparam logic [COUNT_W-1:0] V6_LO_FIRST  = 17'd16;
    localparam logic [COUNT_W-1:0] V6_LO_LAST   = 17'd23;

    localparam logic [LEN_W-1:0] MAX_IP_LEN = 18'd65532;
    localparam logic [LEN_W-1:0] PLEN_SAT   = 18'd65535;

    typedef struct packed {
        logic        action;
        logic [7:0]  packet_byte;
        logic        last_byte;
        logic [2:0]  entry_index;
        logic [1:0]  word_select;
        logic [63:0] table_word;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  chosen_mux_id;
        logic [1:0]  pad_count;
        logic [15:0] padded_length;
        logic [31:0] header_word;
    } result_t;

    // packet state as it stands after the current byte
    typedef struct packed {
        logic [3:0]       version;
        logic [31:0]      v4_src;
        logic [63:0]      v6_hi;
        logic [63:0]      v6_lo;
        logic [LEN_W-1:0] len;
    } capture_t;

    typedef struct packed {
        logic        en;
        logic [2:0]  index;
        logic [1:0]  sel;
        logic [63:0] data;
    } table_wr_t;

endpackage

`default_nettype wire

@@ design/qmap_uplink_header_builder_core.sv @@
// ----------------------------------------------------------------------------
// qmap_uplink_header_builder_core
// Builds the 4-byte mux header for an uplink IP packet streamed byte by byte.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle unless a last byte waits on a held
// result. A transaction is either a packet byte or a mux table word write; the
// last byte of a packet yields one result via the input and result registers;
// other transactions yield none. Capture, the parallel compare over all table
// entries and the length padding all sit between those two registers. The mux
// table is held in flip-flops and cleared by reset, so the block is ready
// right after reset. default_mux_id is written through cfg_wr_en/cfg_wr_data
// and should only change while no packet is in flight.
`default_nettype none

module qmap_uplink_header_builder_core #(
    parameter int MUX_ENTRIES = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [7:0]            cfg_wr_data,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire qmap_hb_pkg::in_item_t s_item,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output qmap_hb_pkg::result_t       m_result
);

    logic                  in_valid_reg;
    qmap_hb_pkg::in_item_t in_item_reg;
    logic                  out_valid_reg;
    qmap_hb_pkg::result_t  out_result_reg, out_result_next;
    logic [7:0]            default_mux_reg;

    logic                  is_packet;
    logic                  emits;
    logic                  advance;

    qmap_hb_pkg::capture_t  cap;
    qmap_hb_pkg::table_wr_t tbl_wr;
    logic [7:0]             chosen_mux_id;

    logic                         is_ip;
    logic                         is_v6;
    logic [1:0]                   pad;
    logic [qmap_hb_pkg::LEN_W-1:0] plen_full;
    logic [15:0]                  plen;

    always_comb begin
        is_packet = (in_item_reg.action == qmap_hb_pkg::ACTION_PACKET);
        emits     = in_valid_reg && is_packet && in_item_reg.last_byte;
        advance   = in_valid_reg && (!emits || !out_valid_reg || m_ready);
        s_ready   = !in_valid_reg || advance;
    end

    always_comb begin
        tbl_wr.en    = advance && !is_packet;
        tbl_wr.index = in_item_reg.entry_index;
        tbl_wr.sel   = in_item_reg.word_select;
        tbl_wr.data  = in_item_reg.table_word;
    end

    qmap_hb_capture u_capture (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pkt_en   (advance && is_packet),
        .pkt_byte (in_item_reg.packet_byte),
        .pkt_last (in_item_reg.last_byte),
        .cap      (cap)
    );

    qmap_hb_table #(
        .MUX_ENTRIES (MUX_ENTRIES)
    ) u_table (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .wr             (tbl_wr),
        .cap            (cap),
        .default_mux_id (default_mux_reg),
        .chosen_mux_id  (chosen_mux_id)
    );

    // header formatting
    always_comb begin
        is_v6     = (cap.version == qmap_hb_pkg::VERSION_IPV6);
        is_ip     = is_v6 || (cap.version == qmap_hb_pkg::VERSION_IPV4);
        pad       = 2'd0 - cap.len[1:0];
        plen_full = cap.len + {{(qmap_hb_pkg::LEN_W-2){1'b0}}, pad};
        plen      = (plen_full > qmap_hb_pkg::PLEN_SAT) ? 16'hFFFF : plen_full[15:0];

        out_result_next = '0;
        if (!is_ip) begin
            out_result_next.status = qmap_hb_pkg::STATUS_NOT_IP;
        end else begin
            out_result_next.chosen_mux_id = chosen_mux_id;
            out_result_next.pad_count     = pad;
            out_result_next.padded_length = plen;
            if (cap.len > qmap_hb_pkg::MAX_IP_LEN) begin
                out_result_next.status = qmap_hb_pkg::STATUS_OVERFLOW;
            end else begin
                out_result_next.status = is_v6 ? qmap_hb_pkg::STATUS_IPV6
                                               : qmap_hb_pkg::STATUS_IPV4;
                out_result_next.header_word = {6'b0, pad, chosen_mux_id, plen};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            default_mux_reg <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance && emits) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                default_mux_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance && emits) begin
            out_result_reg <= out_result_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_result_reg;

endmodule

`default_nettype wire

@@ design/qmap_hb_capture.sv @@
// ----------------------------------------------------------------------------
// qmap_hb_capture
// Byte counter, version nibble and source address capture for one packet.
// ----------------------------------------------------------------------------
`default_nettype none

module qmap_hb_capture (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 pkt_en,
    input  wire logic [7:0]           pkt_byte,
    input  wire logic                 pkt_last,
    output qmap_hb_pkg::capture_t     cap
);

    logic [qmap_hb_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [3:0]  version_reg, version_next;
    logic [31:0] v4_reg, v4_next;
    logic [63:0] v6_hi_reg, v6_hi_next;
    logic [63:0] v6_lo_reg, v6_lo_next;

    always_comb begin
        version_next = version_reg;
        v4_next      = v4_reg;
        v6_hi_next   = v6_hi_reg;
        v6_lo_next   = v6_lo_reg;

        // first byte starts a fresh capture
        if (count_reg == '0) begin
            version_next = pkt_byte[7:4];
            v4_next      = '0;
            v6_hi_next   = '0;
            v6_lo_next   = '0;
        end
        if (count_reg >= qmap_hb_pkg::V4_SRC_FIRST && count_reg <= qmap_hb_pkg::V4_SRC_LAST) begin
            v4_next = {v4_next[23:0], pkt_byte};
        end
        if (count_reg >= qmap_hb_pkg::V6_HI_FIRST && count_reg <= qmap_hb_pkg::V6_HI_LAST) begin
            v6_hi_next = {v6_hi_next[55:0], pkt_byte};
        end
        if (count_reg >= qmap_hb_pkg::V6_LO_FIRST && count_reg <= qmap_hb_pkg::V6_LO_LAST) begin
            v6_lo_next = {v6_lo_next[55:0], pkt_byte};
        end

        if (pkt_last) begin
            count_next = '0;
        end else if (count_reg != qmap_hb_pkg::COUNT_MAX) begin
            count_next = count_reg + 1'b1;
        end else begin
            count_next = count_reg;
        end

        cap.version = version_next;
        cap.v4_src  = v4_next;
        cap.v6_hi   = v6_hi_next;
        cap.v6_lo   = v6_lo_next;
        cap.len     = {1'b0, count_reg} + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            version_reg <= '0;
            v4_reg      <= '0;
            v6_hi_reg   <= '0;
            v6_lo_reg   <= '0;
        end else if (pkt_en) begin
            count_reg   <= count_next;
            version_reg <= version_next;
            v4_reg      <= v4_next;
            v6_hi_reg   <= v6_hi_next;
            v6_lo_reg   <= v6_lo_next;
        end
    end

endmodule

`default_nettype wire

@@ design/qmap_hb_table.sv @@
// ----------------------------------------------------------------------------
// qmap_hb_table
// Mux table storage and parallel source address match, last match wins.
// ----------------------------------------------------------------------------
`default_nettype none

module qmap_hb_table #(
    parameter int MUX_ENTRIES = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire qmap_hb_pkg::table_wr_t wr,
    input  wire qmap_hb_pkg::capture_t  cap,
    input  wire logic [7:0]            default_mux_id,
    output logic [7:0]                 chosen_mux_id
);

    logic [31:0] v4_tbl_reg  [MUX_ENTRIES];
    logic [63:0] v6_hi_tbl_reg [MUX_ENTRIES];
    logic [63:0] v6_lo_tbl_reg [MUX_ENTRIES];
    logic [7:0]  mux_tbl_reg [MUX_ENTRIES];

    logic                   is_v6;
    logic                   zero_src;
    logic [MUX_ENTRIES-1:0] hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MUX_ENTRIES; i++) begin
                v4_tbl_reg[i]    <= '0;
                v6_hi_tbl_reg[i] <= '0;
                v6_lo_tbl_reg[i] <= '0;
                mux_tbl_reg[i]   <= '0;
            end
        end else if (wr.en) begin
            // an index past the table matches no entry and is dropped
            for (int i = 0; i < MUX_ENTRIES; i++) begin
                if (int'(wr.index) == i) begin
                    unique case (wr.sel)
                        qmap_hb_pkg::SEL_IPV4:    v4_tbl_reg[i]    <= wr.data[31:0];
                        qmap_hb_pkg::SEL_IPV6_HI: v6_hi_tbl_reg[i] <= wr.data;
                        qmap_hb_pkg::SEL_IPV6_LO: v6_lo_tbl_reg[i] <= wr.data;
                        qmap_hb_pkg::SEL_MUX_ID:  mux_tbl_reg[i]   <= wr.data[7:0];
                        default:                  mux_tbl_reg[i]   <= mux_tbl_reg[i];
                    endcase
                end
            end
        end
    end

    always_comb begin
        is_v6 = (cap.version == qmap_hb_pkg::VERSION_IPV6);
        zero_src = is_v6 ? (cap.v6_hi == '0 && cap.v6_lo == '0) : (cap.v4_src == '0);
        for (int i = 0; i < MUX_ENTRIES; i++) begin
            hit[i] = is_v6 ? (v6_hi_tbl_reg[i] == cap.v6_hi && v6_lo_tbl_reg[i] == cap.v6_lo)
                           : (v4_tbl_reg[i] == cap.v4_src);
        end
    end

    always_comb begin
        chosen_mux_id = default_mux_id;
        if (!zero_src) begin
            for (int i = 0; i < MUX_ENTRIES; i++) begin
                if (hit[i]) begin
                    chosen_mux_id = mux_tbl_reg[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/qmap_uplink_header_builder_core_tb.sv @@
// ----------------------------------------------------------------------------
// qmap_uplink_header_builder_core_tb
// Streams IP packets and mux table writes into the header builder. Each
// header is checked field by field against a predicted capture, table lookup
// and length padding, with random idle cycles on both channels.
// ----------------------------------------------------------------------------

module qmap_uplink_header_builder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qmap_hb_pkg::*;

    localparam int          NUM_ENTRIES  = 8;
    localparam longint      LIMIT_CYCLES = 2_000_000;
    localparam logic [16:0] CNT_SAT      = 17'h1FFFF;
    localparam logic [17:0] MAX_IP_BYTES = 18'd65532;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_valid     = 1'b0;
    in_item_t    s_item      = '0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    result_t     m_result;

    // predicted block state
    logic [16:0] pkt_count   = '0;
    logic [3:0]  pkt_version = '0;
    logic [31:0] src_v4      = '0;
    logic [63:0] src_v6_hi   = '0;
    logic [63:0] src_v6_lo   = '0;
    logic [31:0] tbl_v4    [NUM_ENTRIES] = '{default: '0};
    logic [63:0] tbl_v6_hi [NUM_ENTRIES] = '{default: '0};
    logic [63:0] tbl_v6_lo [NUM_ENTRIES] = '{default: '0};
    logic [7:0]  tbl_mux   [NUM_ENTRIES] = '{default: '0};
    logic [7:0]  dflt_mux    = '0;

    result_t     pending_headers[$];
    int unsigned items_sent   = 0;
    int unsigned headers_seen = 0;
    int unsigned error_count  = 0;
    longint      cycles       = 0;
    bit          tx_gaps      = 1'b1;
    bit          rx_gaps      = 1'b1;

    qmap_uplink_header_builder_core #(
        .MUX_ENTRIES(NUM_ENTRIES)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("FAIL qmap_uplink_header_builder_core");
            $finish;
        end
    end

    function automatic logic [7:0] lookup_mux(logic is_v6);
        logic [7:0] mux;
        mux = dflt_mux;
        if (!is_v6) begin
            if (src_v4 != '0) begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                    if (tbl_v4[i] == src_v4) mux = tbl_mux[i];
            end
        end else if (src_v6_hi != '0 || src_v6_lo != '0) begin
            // highest matching entry wins
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (tbl_v6_hi[i] == src_v6_hi && tbl_v6_lo[i] == src_v6_lo)
                    mux = tbl_mux[i];
        end
        return mux;
    endfunction

    function automatic void predict_header(in_item_t it);
        logic [17:0] len;
        logic [17:0] plen;
        logic [1:0]  pad;
        logic        is_v6;
        result_t     r;
        if (it.action == ACTION_TABLE) begin
            case (it.word_select)
                SEL_IPV4:    tbl_v4[it.entry_index]    = it.table_word[31:0];
                SEL_IPV6_HI: tbl_v6_hi[it.entry_index] = it.table_word;
                SEL_IPV6_LO: tbl_v6_lo[it.entry_index] = it.table_word;
                default:     tbl_mux[it.entry_index]   = it.table_word[7:0];
            endcase
            return;
        end
        if (pkt_count == 0) begin
            pkt_version = it.packet_byte[7:4];
            src_v4      = '0;
            src_v6_hi   = '0;
            src_v6_lo   = '0;
        end
        if (pkt_count >= 12 && pkt_count <= 15) src_v4 = {src_v4[23:0], it.packet_byte};
        if (pkt_count >= 8 && pkt_count <= 15) src_v6_hi = {src_v6_hi[55:0], it.packet_byte};
        if (pkt_count >= 16 && pkt_count <= 23) src_v6_lo = {src_v6_lo[55:0], it.packet_byte};
        len = {1'b0, pkt_count} + 18'd1;
        if (pkt_count != CNT_SAT) pkt_count++;
        if (!it.last_byte) return;
        pkt_count = '0;
        r = '0;
        if (pkt_version != VERSION_IPV4 && pkt_version != VERSION_IPV6) begin
            r.status = STATUS_NOT_IP;
        end else begin
            is_v6           = (pkt_version == VERSION_IPV6);
            pad             = 2'd0 - len[1:0];
            plen            = len + pad;
            r.chosen_mux_id = lookup_mux(is_v6);
            r.pad_count     = pad;
            r.padded_length = (plen > 18'h0FFFF) ? 16'hFFFF : plen[15:0];
            if (len > MAX_IP_BYTES) begin
                r.status = STATUS_OVERFLOW;
            end else begin
                r.status      = is_v6 ? STATUS_IPV6 : STATUS_IPV4;
                r.header_word = {6'd0, pad, r.chosen_mux_id, r.padded_length};
            end
        end
        pending_headers.push_back(r);
    endfunction

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (act !== exp) begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, exp, act);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) predict_header(s_item);
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            headers_seen++;
            if (pending_headers.size() == 0) begin
                error_count++;
                $display("%0t: header with none expected, actual %p", $time, m_result);
            end else begin
                want = pending_headers.pop_front();
                check_field("status", want.status, m_result.status);
                check_field("chosen_mux_id", want.chosen_mux_id, m_result.chosen_mux_id);
                check_field("pad_count", want.pad_count, m_result.pad_count);
                check_field("padded_length", want.padded_length, m_result.padded_length);
                check_field("header_word", want.header_word, m_result.header_word);
            end
        end
    end

    // result side: random stall before each transaction, with runs of none
    initial begin
        int unsigned stall;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 9) == 0) rx_gaps = ~rx_gaps;
            stall = rx_gaps ? $urandom_range(0, 16) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    function automatic in_item_t random_item();
        in_item_t it;
        it.action      = 1'($urandom_range(0, 1));
        it.packet_byte = 8'($urandom);
        it.last_byte   = 1'($urandom_range(0, 1));
        it.entry_index = 3'($urandom);
        it.word_select = 2'($urandom);
        it.table_word  = {$urandom, $urandom};
        return it;
    endfunction

    // valid stays high across back-to-back transactions
    task automatic send_item(in_item_t it);
        int unsigned gap;
        gap = tx_gaps ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_headers.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_default_mux(logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        dflt_mux   = value;
    endtask

    task automatic write_table(logic [2:0] idx, logic [1:0] sel, logic [63:0] word);
        in_item_t it;
        it             = random_item();
        it.action      = ACTION_TABLE;
        it.entry_index = idx;
        it.word_select = sel;
        it.table_word  = word;
        send_item(it);
    endtask

    // mid is sent after the fifth byte when has_mid is set and len exceeds six
    task automatic send_packet(logic [3:0] ver, int len, logic [31:0] v4, logic [127:0] v6,
                               bit has_mid, in_item_t mid);
        in_item_t it;
        for (int i = 0; i < len; i++) begin
            it        = random_item();
            it.action = ACTION_PACKET;
            if (i == 0) it.packet_byte[7:4] = ver;
            if (ver == VERSION_IPV4 && i >= 12 && i <= 15) it.packet_byte = v4[8*(15-i) +: 8];
            if (ver == VERSION_IPV6 && i >= 8 && i <= 23) it.packet_byte = v6[8*(23-i) +: 8];
            it.last_byte = (i == len - 1);
            send_item(it);
            if (has_mid && i == 4 && len > 6) send_item(mid);
        end
    endtask

    task automatic test_empty_table();
        send_packet(VERSION_IPV4, 20, 32'hC0A8_0001, '0, 1'b0, '0);
        send_packet(VERSION_IPV4, 21, 32'h0000_0000, '0, 1'b0, '0);
        send_packet(VERSION_IPV6, 40, '0, {$urandom, $urandom, $urandom, $urandom}, 1'b0, '0);
        send_packet(4'h5, 30, '0, '0, 1'b0, '0);
        send_packet(VERSION_IPV4, 1, '0, '0, 1'b0, '0);
        wait_drained();
    endtask

    task automatic test_table_lookup();
        in_item_t mid;
        set_default_mux(8'hFF);
        write_table(3'd0, SEL_IPV4, '1);
        write_table(3'd0, SEL_MUX_ID, 64'hFFFF_FFFF_FFFF_FF5A);
        write_table(3'd7, SEL_IPV6_HI, 64'h2001_0DB8_0000_0001);
        write_table(3'd7, SEL_IPV6_LO, '1);
        write_table(3'd7, SEL_MUX_ID, 64'hFFFF_FFFF_FFFF_FF00);
        send_packet(VERSION_IPV4, 22, 32'hFFFF_FFFF, '0, 1'b0, '0);
        send_packet(VERSION_IPV6, 23, '0, {64'h2001_0DB8_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF},
                    1'b0, '0);
        // duplicate address in a higher entry takes over
        write_table(3'd3, SEL_IPV4, 64'h0000_0000_FFFF_FFFF);
        write_table(3'd3, SEL_MUX_ID, 64'h0000_0000_0000_0033);
        send_packet(VERSION_IPV4, 60, 32'hFFFF_FFFF, '0, 1'b0, '0);
        // truncated sources
        send_packet(VERSION_IPV6, 12, '0, {64'h2001_0DB8_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF},
                    1'b0, '0);
        send_packet(VERSION_IPV4, 14, 32'hFFFF_FFFF, '0, 1'b0, '0);
        // table write lands while the packet is in flight
        mid             = random_item();
        mid.action      = ACTION_TABLE;
        mid.entry_index = 3'd5;
        mid.word_select = SEL_IPV4;
        mid.table_word  = 64'hFFFF_FFFF_0A00_0005;
        send_packet(VERSION_IPV4, 20, 32'h0A00_0005, '0, 1'b1, mid);
        send_packet(4'h0, 5, '0, '0, 1'b0, '0);
        send_packet(4'hF, 9, '0, '0, 1'b0, '0);
        wait_drained();
    endtask

    task automatic test_long_packets();
        set_default_mux(8'h00);
        tx_gaps = 1'b0;
        send_packet(VERSION_IPV4, 65532, 32'hFFFF_FFFF, '0, 1'b0, '0);
        send_packet(VERSION_IPV6, 65533, '0, '0, 1'b0, '0);
        // runs the byte counter into saturation
        send_packet(VERSION_IPV4, 131073, 32'hFFFF_FFFF, '0, 1'b0, '0);
        tx_gaps = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_traffic(logic [7:0] dflt, int unsigned n_items,
                                       int unsigned n_headers);
        int unsigned first_item;
        int unsigned first_header;
        int unsigned pick;
        int unsigned j;
        int unsigned k;
        int          len;
        logic [3:0]  ver;
        logic [31:0] v4;
        logic [127:0] v6;
        in_item_t    mid;
        set_default_mux(dflt);
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            write_table(3'(e), SEL_IPV4, {$urandom, $urandom});
            write_table(3'(e), SEL_IPV6_HI, {$urandom, $urandom});
            write_table(3'(e), SEL_IPV6_LO, {$urandom, $urandom});
            write_table(3'(e), SEL_MUX_ID, {$urandom, $urandom});
        end
        first_item   = items_sent;
        first_header = headers_seen;
        while (items_sent - first_item < n_items || headers_seen - first_header < n_headers) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                write_table(3'($urandom), 2'($urandom), {$urandom, $urandom});
            end else if (pick < 8) begin
                // copy one entry's addresses into another
                j = $urandom_range(0, NUM_ENTRIES - 1);
                k = $urandom_range(0, NUM_ENTRIES - 1);
                write_table(3'(j), SEL_IPV4, {32'($urandom), tbl_v4[k]});
                write_table(3'(j), SEL_IPV6_HI, tbl_v6_hi[k]);
                write_table(3'(j), SEL_IPV6_LO, tbl_v6_lo[k]);
                write_table(3'(j), SEL_MUX_ID, {$urandom, $urandom});
            end else if (pick < 14) begin
                send_item(random_item());
            end else begin
                tx_gaps = ($urandom_range(0, 4) != 0);
                pick    = $urandom_range(0, 99);
                ver     = (pick < 45) ? VERSION_IPV4 : (pick < 90) ? VERSION_IPV6
                                                                    : 4'($urandom);
                len     = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 48)
                                                       : $urandom_range(49, 200);
                pick    = $urandom_range(0, 99);
                k       = $urandom_range(0, NUM_ENTRIES - 1);
                if (pick < 60) begin
                    v4 = tbl_v4[k];
                    v6 = {tbl_v6_hi[k], tbl_v6_lo[k]};
                end else if (pick < 85) begin
                    v4 = $urandom;
                    v6 = {$urandom, $urandom, $urandom, $urandom};
                end else begin
                    v4 = '0;
                    v6 = '0;
                end
                mid        = random_item();
                mid.action = ACTION_TABLE;
                send_packet(ver, len, v4, v6, ($urandom_range(0, 19) == 0), mid);
            end
        end
        tx_gaps = 1'b1;
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_table();
        test_table_lookup();
        test_long_packets();
        test_random_traffic(8'($urandom_range(1, 254)), 350, 16);
        test_random_traffic(8'hFF, 350, 16);
        test_random_traffic(8'h00, 350, 16);
        if (error_count == 0) begin
            $display("PASS qmap_uplink_header_builder_core");
        end else begin
            $display("FAIL qmap_uplink_header_builder_core");
        end
        $finish;
    end

endmodule
